// ----- design/bfi_pkg.sv -----
// Shared types and constants for the tape-machine interpreter.
package bfi_pkg;

    // Instruction budget for one step; a step that spends it all answers accepted
    localparam int unsigned STEP_BUDGET = 65536;
    localparam int unsigned BUDGET_W    = $clog2(STEP_BUDGET) + 1;

    // Program characters that the machine acts on
    localparam logic [7:0] CH_RIGHT = 8'h3E;  // '>'
    localparam logic [7:0] CH_LEFT  = 8'h3C;  // '<'
    localparam logic [7:0] CH_INC   = 8'h2B;  // '+'
    localparam logic [7:0] CH_DEC   = 8'h2D;  // '-'
    localparam logic [7:0] CH_OUT   = 8'h2E;  // '.'
    localparam logic [7:0] CH_IN    = 8'h2C;  // ','
    localparam logic [7:0] CH_OPEN  = 8'h5B;  // '['
    localparam logic [7:0] CH_CLOSE = 8'h5D;  // ']'
    localparam logic [7:0] CH_NL    = 8'h0A;  // newline after a finished line

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_CONT  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        EV_OK      = 3'd0,
        EV_OUT     = 3'd1,
        EV_IN      = 3'd2,
        EV_DONE    = 3'd3,
        EV_MEM     = 3'd4,
        EV_BRACKET = 3'd5,
        EV_FULL    = 3'd6,
        EV_IGNORED = 3'd7
    } event_t;

    typedef enum logic [1:0] {
        MODE_LOAD = 2'd0,
        MODE_RUN  = 2'd1,
        MODE_WAIT = 2'd2
    } mode_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_EXEC,
        ST_SCANF,
        ST_SCANF_CHK,
        ST_SCANB,
        ST_SCANB_CHK,
        ST_EMIT
    } state_t;

endpackage

// ----- design/bf_tape_machine_interpreter.sv -----
// Tape-machine interpreter: program store, tape memory and the execution sequencer.
//
// Input channel s_axis_*: one word carries a command (load char, start line,
// continue, clear tape) and a signed 9-bit value. Output channel m_axis_*:
// exactly one word per input word, carrying an event code and a byte.
// The block takes one input word at a time; s_axis_tready is high only while
// the sequencer is idle, and stays high while a finished result still sits in
// the output register.
// Sequence: load, ignored and rejected commands go straight to the emit state.
// A run fetches each instruction, then executes it on the registered program
// and tape read data; a bracket scan steps and then checks each character it
// passes, and the emit state delivers the result; one step stops at the first
// output, input request, end of line, error or after STEP_BUDGET instructions.
// A clear sweeps the tape one cell a cycle. After reset the same sweep zeroes
// the tape before the first input word is taken. If the receiver stalls, the
// finished result holds in the output register and the sequencer waits before
// loading the next one.
module bf_tape_machine_interpreter #(
    parameter int PROGRAM_DEPTH = 1024,
    parameter int TAPE_DEPTH    = 1024,
    parameter int CELL_WIDTH    = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [1:0] command, [10:2] value (signed), rest zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [2:0] event_res, [10:3] out_byte, rest zero
);
    import bfi_pkg::*;

    localparam int PAW = $clog2(PROGRAM_DEPTH);
    localparam int LW  = PAW + 1;
    localparam int TAW = $clog2(TAPE_DEPTH);
    localparam int PW  = TAW + 2;

    // Sequencer and architectural registers
    state_t                 state_reg, state_next;
    mode_t                  mode_reg, mode_next;
    logic [LW-1:0]          len_reg, len_next;
    logic [LW-1:0]          pc_reg, pc_next;
    logic signed [PW-1:0]   ptr_reg, ptr_next;
    logic [BUDGET_W-1:0]    budget_reg, budget_next;
    logic [LW-1:0]          depth_reg, depth_next;
    logic [TAW-1:0]         clr_addr_reg, clr_addr_next;
    logic                   clr_reply_reg, clr_reply_next;
    event_t                 ev_reg, ev_next;
    logic [7:0]             byte_reg, byte_next;
    logic                   m_valid_reg, m_valid_next;
    logic [15:0]            m_data_reg, m_data_next;

    // Memory ports
    logic [7:0]             prog_mem [PROGRAM_DEPTH];
    logic                   prog_we;
    logic [PAW-1:0]         prog_waddr, prog_raddr;
    logic [7:0]             prog_wdata, prog_q;
    logic [CELL_WIDTH-1:0]  tape_mem [TAPE_DEPTH];
    logic                   tape_we;
    logic [TAW-1:0]         tape_waddr, tape_raddr;
    logic [CELL_WIDTH-1:0]  tape_wdata, tape_q;

    // Decoded input word and status
    logic                   in_fire;
    cmd_t                   in_cmd;
    logic signed [8:0]      in_value;
    logic signed [31:0]     in_value_ext;
    logic                   in_value_bad;
    logic                   ptr_bad;
    logic                   out_free;
    logic                   tape_zero;
    logic [TAW-1:0]         ptr_idx;
    logic [LW-1:0]          pc_inc, pc_dec;
    logic                   clr_last;

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign in_cmd        = cmd_t'(s_axis_tdata[1:0]);
    assign in_value      = $signed(s_axis_tdata[10:2]);
    assign in_value_ext  = 32'(in_value);
    assign in_value_bad  = in_value[8] || (in_value == 9'sd0);
    assign ptr_bad       = ptr_reg[PW-1] || (ptr_reg[PW-2:0] >= (PW-1)'(TAPE_DEPTH));
    assign ptr_idx       = ptr_reg[TAW-1:0];
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign tape_zero     = (tape_q == '0);
    assign pc_inc        = pc_reg + LW'(1);
    assign pc_dec        = pc_reg - LW'(1);
    assign clr_last      = (clr_addr_reg == TAW'(TAPE_DEPTH - 1));

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                    state_next = clr_reply_reg ? ST_EMIT : ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (in_cmd)
                        CMD_START: state_next = (mode_reg == MODE_LOAD) ? ST_FETCH : ST_EMIT;
                        CMD_CONT:  state_next = (mode_reg != MODE_LOAD) ? ST_FETCH : ST_EMIT;
                        CMD_CLEAR: state_next = ST_CLEAR;
                        default:   state_next = ST_EMIT;
                    endcase
                end
            end
            ST_FETCH:
            begin
                if (budget_reg == BUDGET_W'(STEP_BUDGET) || pc_reg >= len_reg || ptr_bad)
                    state_next = ST_EMIT;
                else
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (prog_q == CH_OUT || prog_q == CH_IN)
                    state_next = ST_EMIT;
                else if (prog_q == CH_OPEN && tape_zero)
                    state_next = ST_SCANF;
                else if (prog_q == CH_CLOSE && !tape_zero)
                    state_next = ST_SCANB;
                else
                    state_next = ST_FETCH;
            end
            ST_SCANF:
                state_next = (pc_inc >= len_reg) ? ST_EMIT : ST_SCANF_CHK;
            ST_SCANF_CHK:
                state_next = (prog_q == CH_CLOSE && depth_reg == '0) ? ST_FETCH : ST_SCANF;
            ST_SCANB:
                state_next = (pc_reg == '0) ? ST_EMIT : ST_SCANB_CHK;
            ST_SCANB_CHK:
                state_next = (prog_q == CH_OPEN && depth_reg == '0) ? ST_FETCH : ST_SCANB;
            ST_EMIT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Datapath, memory controls and result
    always_comb
    begin
        mode_next      = mode_reg;
        len_next       = len_reg;
        pc_next        = pc_reg;
        ptr_next       = ptr_reg;
        budget_next    = budget_reg;
        depth_next     = depth_reg;
        clr_addr_next  = clr_addr_reg;
        clr_reply_next = clr_reply_reg;
        ev_next        = ev_reg;
        byte_next      = byte_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        m_data_next    = m_data_reg;
        prog_we        = 1'b0;
        prog_waddr     = len_reg[PAW-1:0];
        prog_wdata     = in_value[7:0];
        prog_raddr     = pc_reg[PAW-1:0];
        tape_we        = 1'b0;
        tape_waddr     = ptr_idx;
        tape_wdata     = CELL_WIDTH'(in_value_ext);
        tape_raddr     = ptr_idx;

        case (state_reg)
            // Sweep zeros through the tape
            ST_CLEAR:
            begin
                tape_we       = 1'b1;
                tape_waddr    = clr_addr_reg;
                tape_wdata    = '0;
                clr_addr_next = clr_addr_reg + TAW'(1);
                if (clr_last)
                begin
                    clr_addr_next = '0;
                    ev_next       = EV_OK;
                    byte_next     = 8'd0;
                end
            end
            // Take a command word
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    ev_next   = EV_IGNORED;
                    byte_next = 8'd0;
                    budget_next = '0;
                    depth_next  = '0;
                    case (in_cmd)
                        CMD_LOAD:
                        begin
                            if (mode_reg != MODE_LOAD || in_value_bad)
                                ev_next = EV_IGNORED;
                            else if (len_reg >= LW'(PROGRAM_DEPTH))
                                ev_next = EV_FULL;
                            else
                            begin
                                prog_we  = 1'b1;
                                len_next = len_reg + LW'(1);
                                ev_next  = EV_OK;
                            end
                        end
                        CMD_START:
                        begin
                            if (mode_reg == MODE_LOAD)
                            begin
                                pc_next   = '0;
                                mode_next = MODE_RUN;
                            end
                        end
                        CMD_CONT:
                        begin
                            if (mode_reg == MODE_WAIT)
                            begin
                                tape_we   = !ptr_bad;
                                pc_next   = pc_inc;
                                mode_next = MODE_RUN;
                            end
                        end
                        default:
                        begin
                            ptr_next       = '0;
                            clr_reply_next = 1'b1;
                        end
                    endcase
                end
            end
            // Check the step, then read the instruction and the cell
            ST_FETCH:
            begin
                if (budget_reg == BUDGET_W'(STEP_BUDGET))
                begin
                    ev_next   = EV_OK;
                    byte_next = 8'd0;
                end
                else if (pc_reg >= len_reg)
                begin
                    ev_next   = EV_DONE;
                    byte_next = CH_NL;
                    len_next  = '0;
                    pc_next   = '0;
                    mode_next = MODE_LOAD;
                end
                else if (ptr_bad)
                begin
                    ev_next   = EV_MEM;
                    byte_next = 8'd0;
                    len_next  = '0;
                    pc_next   = '0;
                    mode_next = MODE_LOAD;
                end
            end
            // Execute one instruction
            ST_EXEC:
            begin
                pc_next     = pc_inc;
                budget_next = budget_reg + BUDGET_W'(1);
                tape_wdata  = CELL_WIDTH'(tape_q + CELL_WIDTH'(1));
                case (prog_q)
                    CH_RIGHT: ptr_next = ptr_reg + PW'(1);
                    CH_LEFT:  ptr_next = ptr_reg - PW'(1);
                    CH_INC:   tape_we  = 1'b1;
                    CH_DEC:
                    begin
                        tape_we    = 1'b1;
                        tape_wdata = CELL_WIDTH'(tape_q - CELL_WIDTH'(1));
                    end
                    CH_OUT:
                    begin
                        ev_next   = EV_OUT;
                        byte_next = tape_q[7:0];
                    end
                    CH_IN:
                    begin
                        pc_next   = pc_reg;
                        mode_next = MODE_WAIT;
                        ev_next   = EV_IN;
                        byte_next = 8'd0;
                    end
                    CH_OPEN:
                    begin
                        if (tape_zero)
                        begin
                            pc_next     = pc_reg;
                            budget_next = budget_reg;
                            depth_next  = '0;
                        end
                    end
                    CH_CLOSE:
                    begin
                        if (!tape_zero)
                        begin
                            pc_next     = pc_reg;
                            budget_next = budget_reg;
                            depth_next  = '0;
                        end
                    end
                    default:
                        ptr_next = ptr_reg;
                endcase
            end
            // Advance the forward scan and read the next character
            ST_SCANF:
            begin
                prog_raddr = pc_inc[PAW-1:0];
                pc_next    = pc_inc;
                if (pc_inc >= len_reg)
                begin
                    ev_next   = EV_BRACKET;
                    byte_next = 8'd0;
                    len_next  = '0;
                    pc_next   = '0;
                    mode_next = MODE_LOAD;
                end
            end
            ST_SCANF_CHK:
            begin
                if (prog_q == CH_OPEN)
                    depth_next = depth_reg + LW'(1);
                else if (prog_q == CH_CLOSE)
                begin
                    if (depth_reg == '0)
                    begin
                        pc_next     = pc_inc;
                        budget_next = budget_reg + BUDGET_W'(1);
                    end
                    else
                        depth_next = depth_reg - LW'(1);
                end
            end
            // Step the backward scan and read the previous character
            ST_SCANB:
            begin
                prog_raddr = pc_dec[PAW-1:0];
                pc_next    = pc_dec;
                if (pc_reg == '0)
                begin
                    ev_next   = EV_BRACKET;
                    byte_next = 8'd0;
                    len_next  = '0;
                    pc_next   = '0;
                    mode_next = MODE_LOAD;
                end
            end
            ST_SCANB_CHK:
            begin
                if (prog_q == CH_CLOSE)
                    depth_next = depth_reg + LW'(1);
                else if (prog_q == CH_OPEN)
                begin
                    if (depth_reg == '0)
                    begin
                        pc_next     = pc_inc;
                        budget_next = budget_reg + BUDGET_W'(1);
                    end
                    else
                        depth_next = depth_reg - LW'(1);
                end
            end
            // Hand the result word to the output register
            ST_EMIT:
            begin
                if (out_free)
                begin
                    m_valid_next   = 1'b1;
                    m_data_next    = {5'd0, byte_reg, ev_reg};
                    clr_reply_next = 1'b0;
                end
            end
            default:
                mode_next = mode_reg;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            mode_reg      <= MODE_LOAD;
            len_reg       <= '0;
            pc_reg        <= '0;
            ptr_reg       <= '0;
            budget_reg    <= '0;
            depth_reg     <= '0;
            clr_addr_reg  <= '0;
            clr_reply_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            len_reg       <= len_next;
            pc_reg        <= pc_next;
            ptr_reg       <= ptr_next;
            budget_reg    <= budget_next;
            depth_reg     <= depth_next;
            clr_addr_reg  <= clr_addr_next;
            clr_reply_reg <= clr_reply_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        ev_reg     <= ev_next;
        byte_reg   <= byte_next;
        m_data_reg <= m_data_next;
    end

    // Program store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (prog_we)
            prog_mem[prog_waddr] <= prog_wdata;
        prog_q <= prog_mem[prog_raddr];
    end

    // Tape: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (tape_we)
            tape_mem[tape_waddr] <= tape_wdata;
        tape_q <= tape_mem[tape_raddr];
    end

    // The pointer strays at most one cell beyond either end
    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (ptr_reg >= -PW'(1)) && (ptr_reg <= PW'(TAPE_DEPTH)))
        else $error("tape pointer beyond one cell out of range");

    // A fetch never sees the counter past the end of the line
    a_pc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH) |-> (pc_reg <= len_reg))
        else $error("program counter past program length at fetch");

    // The program never outgrows its store
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LW'(PROGRAM_DEPTH))
        else $error("program length exceeds store depth");

    // One word at a time: after a take, the input closes
    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_axis_tready)
        else $error("input taken while a word is in progress");

    // An emit with room in the output register presents the result next cycle
    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_free) |=> (m_valid_reg && state_reg == ST_IDLE))
        else $error("result not presented after emit");

endmodule

// ----- bench/bf_event_checker.sv -----
// Checker for the tape-machine interpreter: predicts each answer word and compares it.
module bf_event_checker
    import bfi_pkg::*;
#(
    parameter int PROGRAM_DEPTH = 1024,
    parameter int TAPE_DEPTH    = 1024,
    parameter int CELL_WIDTH    = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [1:0] command, [10:2] value (signed)
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // [2:0] event_res, [10:3] out_byte
    output int          fail_count,
    output int          pending,
    output event_t      last_predicted
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        event_t     ev;
        logic [7:0] ob;
    } answer_t;

    localparam int SHOW_LIMIT = 10;

    // Shadow of the machine
    logic [7:0]            prog_mem [PROGRAM_DEPTH];
    int unsigned           prog_len;
    int unsigned           prog_pc;
    logic [CELL_WIDTH-1:0] cells [TAPE_DEPTH];
    int                    head;
    mode_t                 mode;

    answer_t owed_answers [$];
    int      faults;

    initial
    begin
        foreach (prog_mem[i]) prog_mem[i] = '0;
        foreach (cells[i]) cells[i] = '0;
        prog_len       = 0;
        prog_pc        = 0;
        head           = 0;
        mode           = MODE_LOAD;
        faults         = 0;
        fail_count     = 0;
        pending        = 0;
        last_predicted = EV_OK;
    end

    // End the line: empty the program and go back to loading
    function automatic answer_t close_line(event_t ev, logic [7:0] ob);
        prog_len = 0;
        prog_pc  = 0;
        mode     = MODE_LOAD;
        return answer_t'{ev, ob};
    endfunction

    // Execute from the current position until an event or the budget runs out
    function automatic answer_t run_until_event();
        int unsigned spent;
        int unsigned pc;
        int unsigned depth;
        logic [7:0]  ch;
        for (spent = 0; spent < STEP_BUDGET; spent++)
        begin
            pc = prog_pc;
            if (pc >= prog_len)
                return close_line(EV_DONE, CH_NL);
            if (head < 0 || head >= TAPE_DEPTH)
                return close_line(EV_MEM, 8'd0);
            ch = prog_mem[pc];
            if (ch == CH_RIGHT)
                head++;
            else if (ch == CH_LEFT)
                head--;
            else if (ch == CH_INC)
                cells[head] = cells[head] + 1'b1;
            else if (ch == CH_DEC)
                cells[head] = cells[head] - 1'b1;
            else if (ch == CH_OUT)
            begin
                prog_pc = pc + 1;
                return answer_t'{EV_OUT, cells[head][7:0]};
            end
            else if (ch == CH_IN)
            begin
                mode = MODE_WAIT;
                return answer_t'{EV_IN, 8'd0};
            end
            else if (ch == CH_OPEN && cells[head] == '0)
            begin
                // skip forward to the matching close
                depth = 0;
                forever
                begin
                    pc++;
                    if (pc >= prog_len)
                        return close_line(EV_BRACKET, 8'd0);
                    if (prog_mem[pc] == CH_OPEN)
                        depth++;
                    else if (prog_mem[pc] == CH_CLOSE)
                    begin
                        if (depth == 0)
                            break;
                        depth--;
                    end
                end
            end
            else if (ch == CH_CLOSE && cells[head] != '0)
            begin
                // walk back to the matching open
                depth = 0;
                forever
                begin
                    if (pc == 0)
                        return close_line(EV_BRACKET, 8'd0);
                    pc--;
                    if (prog_mem[pc] == CH_CLOSE)
                        depth++;
                    else if (prog_mem[pc] == CH_OPEN)
                    begin
                        if (depth == 0)
                            break;
                        depth--;
                    end
                end
            end
            prog_pc = pc + 1;
        end
        return answer_t'{EV_OK, 8'd0};
    endfunction

    // Answer to one input word; advances the shadow state
    function automatic answer_t interpret_word(cmd_t cmd, logic signed [8:0] v);
        logic signed [31:0] wide;
        case (cmd)
            CMD_LOAD:
            begin
                if (mode != MODE_LOAD || v <= 0)
                    return answer_t'{EV_IGNORED, 8'd0};
                if (prog_len >= PROGRAM_DEPTH)
                    return answer_t'{EV_FULL, 8'd0};
                prog_mem[prog_len] = v[7:0];
                prog_len++;
                return answer_t'{EV_OK, 8'd0};
            end
            CMD_START:
            begin
                if (mode != MODE_LOAD)
                    return answer_t'{EV_IGNORED, 8'd0};
                prog_pc = 0;
                mode    = MODE_RUN;
                return run_until_event();
            end
            CMD_CONT:
            begin
                if (mode == MODE_WAIT)
                begin
                    wide = v;
                    if (head >= 0 && head < TAPE_DEPTH)
                        cells[head] = wide[CELL_WIDTH-1:0];
                    prog_pc++;
                    mode = MODE_RUN;
                    return run_until_event();
                end
                if (mode == MODE_RUN)
                    return run_until_event();
                return answer_t'{EV_IGNORED, 8'd0};
            end
            default:
            begin
                foreach (cells[i]) cells[i] = '0;
                head = 0;
                return answer_t'{EV_OK, 8'd0};
            end
        endcase
    endfunction

    // Count a fault; show only the first few
    task automatic log_fault(string what, int want, int got);
        faults++;
        if (faults <= SHOW_LIMIT)
            $display("[%0t] checker: %s expected %0d got %0d", $realtime, what, want, got);
    endtask

    // Predict on accepted input words, compare accepted answer words
    always @(posedge clk)
    begin
        answer_t due;
        answer_t seen;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                due = interpret_word(cmd_t'(s_axis_tdata[1:0]), $signed(s_axis_tdata[10:2]));
                owed_answers.push_back(due);
                last_predicted <= due.ev;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen = answer_t'{event_t'(m_axis_tdata[2:0]), m_axis_tdata[10:3]};
                if (owed_answers.size() == 0)
                    log_fault("unexpected word, event", -1, int'(seen.ev));
                else
                begin
                    due = owed_answers.pop_front();
                    if (seen.ev !== due.ev)
                        log_fault("event_res", int'(due.ev), int'(seen.ev));
                    if (seen.ob !== due.ob)
                        log_fault("out_byte", int'(due.ob), int'(seen.ob));
                end
            end
            pending    <= owed_answers.size();
            fail_count <= faults;
        end
    end

endmodule

// ----- bench/tb_bf_tape_machine_interpreter.sv -----
// Testbench top for the tape-machine interpreter: stimulus, clock, reset and verdict.
module tb_bf_tape_machine_interpreter;
    timeunit 1ns;
    timeprecision 1ps;

    import bfi_pkg::*;

    localparam int PROGRAM_DEPTH = 1024;
    localparam int TAPE_DEPTH    = 1024;
    localparam int CELL_WIDTH    = 32;
    localparam int RUN_WORDS     = 950;
    localparam int IDLE_PCT      = 28;
    localparam int TAIL_CYCLES   = 40;
    // Hang guard: leaves room for full-budget steps even with both sides stalling
    localparam int unsigned CYCLE_LIMIT = 4_000_000;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;     // [1:0] command, [10:2] value (signed), rest zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;           // [2:0] event_res, [10:3] out_byte, rest zero

    int          fail_count;
    int          pending;
    event_t      last_predicted;

    bit          calm         = 1'b0;
    int unsigned cycles       = 0;
    int          useful_words = 0;
    logic [7:0]  line_text [$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    bf_tape_machine_interpreter #(
        .PROGRAM_DEPTH (PROGRAM_DEPTH),
        .TAPE_DEPTH    (TAPE_DEPTH),
        .CELL_WIDTH    (CELL_WIDTH)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    bf_event_checker #(
        .PROGRAM_DEPTH (PROGRAM_DEPTH),
        .TAPE_DEPTH    (TAPE_DEPTH),
        .CELL_WIDTH    (CELL_WIDTH)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .fail_count     (fail_count),
        .pending        (pending),
        .last_predicted (last_predicted)
    );

    // Stall the receiver at random, and stop a run that hangs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (calm)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Offer one word, idling first at random, and hold it until taken
    task automatic push_word(input cmd_t cmd, input logic [8:0] val, input bit useful);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, val, cmd};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (useful)
            useful_words++;
    endtask

    // Drop valid and hold off until every answer has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Append n program characters, packed first character highest
    function automatic void add_chars(logic [63:0] chars, int n);
        for (int i = n - 1; i >= 0; i--)
            line_text.push_back(chars[8*i +: 8]);
    endfunction

    // A character the machine passes over
    function automatic logic [7:0] plain_char();
        logic [7:0] ch;
        do
            ch = 8'($urandom_range(1, 255));
        while (ch inside {CH_RIGHT, CH_LEFT, CH_INC, CH_DEC, CH_OUT, CH_IN, CH_OPEN, CH_CLOSE});
        return ch;
    endfunction

    // Build a line from pieces that keep every cell small and non-negative,
    // so loops end quickly; at most one stray bracket per line
    function automatic void compose_line();
        int  k;
        bit  stray_used;
        line_text.delete();
        stray_used = 1'b0;
        repeat ($urandom_range(1, 8))
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    k = $urandom_range(1, 4);
                    repeat (k) add_chars(CH_INC, 1);
                    repeat ($urandom_range(0, k)) add_chars(CH_DEC, 1);
                end
                1: add_chars(($urandom_range(99) < 60) ? CH_RIGHT : CH_LEFT, 1);
                2: add_chars(CH_OUT, 1);
                3:
                begin
                    // read, maybe echo, then bring the cell back to zero
                    add_chars(CH_IN, 1);
                    if ($urandom_range(1))
                        add_chars(CH_OUT, 1);
                    add_chars({CH_INC, CH_OPEN, CH_DEC, CH_CLOSE}, 4);
                end
                4: add_chars({CH_OPEN, CH_DEC, CH_CLOSE}, 3);
                5: add_chars({CH_OPEN, CH_DEC, CH_RIGHT, CH_INC, CH_LEFT, CH_CLOSE}, 6);
                6: add_chars({CH_OPEN, CH_RIGHT, CH_CLOSE}, 3);
                7: repeat ($urandom_range(1, 3)) add_chars(plain_char(), 1);
                8: add_chars({CH_OPEN, CH_RIGHT, CH_OPEN, CH_DEC, CH_CLOSE, CH_INC,
                              CH_LEFT, CH_DEC, CH_CLOSE}, 9);
                default:
                begin
                    if (!stray_used)
                        add_chars($urandom_range(1) ? CH_OPEN : CH_CLOSE, 1);
                    stray_used = 1'b1;
                end
            endcase
        end
    endfunction

    // Start the loaded line and keep it going until it ends
    task automatic run_line();
        event_t ev;
        logic [8:0] reply;
        push_word(CMD_START, 9'($urandom), 1'b1);
        forever
        begin
            wait_drained();
            ev = last_predicted;
            if (ev inside {EV_DONE, EV_MEM, EV_BRACKET, EV_IGNORED, EV_FULL})
                return;
            // a step that used up its budget: clear the tape so the loop can end
            if (ev == EV_OK)
                push_word(CMD_CLEAR, 9'($urandom), 1'b1);
            // load or start while the line runs is dropped
            if ($urandom_range(9) == 0)
                push_word(cmd_t'($urandom_range(1)), 9'($urandom), 1'b0);
            if (ev == EV_IN)
                reply = ($urandom_range(9) == 0) ? 9'h1FF : 9'($urandom_range(0, 255));
            else
                reply = 9'($urandom);
            push_word(CMD_CONT, reply, 1'b1);
        end
    endtask

    initial
    begin
        bit filled;
        filled = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: dropped words, output, input with the most negative value,
        // pointer below zero, empty line, unmatched brackets, budget exhaustion
        push_word(CMD_LOAD, 9'd0, 1'b1);
        push_word(CMD_CONT, 9'd5, 1'b1);
        push_word(CMD_LOAD, {1'b0, CH_INC}, 1'b1);
        push_word(CMD_LOAD, {1'b0, CH_OUT}, 1'b1);
        push_word(CMD_LOAD, {1'b0, CH_IN}, 1'b1);
        push_word(CMD_LOAD, {1'b0, CH_OUT}, 1'b1);
        push_word(CMD_LOAD, {1'b0, CH_LEFT}, 1'b1);
        push_word(CMD_LOAD, {1'b0, CH_OUT}, 1'b1);
        push_word(CMD_START, 9'd0, 1'b1);
        push_word(CMD_LOAD, 9'd255, 1'b1);
        push_word(CMD_START, 9'd0, 1'b1);
        push_word(CMD_CONT, 9'h0AA, 1'b1);
        push_word(CMD_START, 9'd0, 1'b1);
        push_word(CMD_CONT, 9'h100, 1'b1);
        push_word(CMD_CONT, 9'd0, 1'b1);
        push_word(CMD_START, 9'd0, 1'b1);
        push_word(CMD_LOAD, 9'd1, 1'b1);
        push_word(CMD_START, 9'd0, 1'b1);
        push_word(CMD_CLEAR, 9'h1FF, 1'b1);
        push_word(CMD_LOAD, {1'b0, CH_OPEN}, 1'b1);
        push_word(CMD_START, 9'd0, 1'b1);
        push_word(CMD_LOAD, {1'b0, CH_DEC}, 1'b1);
        push_word(CMD_LOAD, {1'b0, CH_CLOSE}, 1'b1);
        push_word(CMD_START, 9'd0, 1'b1);
        push_word(CMD_LOAD, {1'b0, CH_OPEN}, 1'b1);
        push_word(CMD_LOAD, {1'b0, CH_CLOSE}, 1'b1);
        push_word(CMD_START, 9'd0, 1'b1);
        push_word(CMD_CLEAR, 9'd0, 1'b1);
        push_word(CMD_CONT, 9'd0, 1'b1);
        wait_drained();

        // Random lines with noise between and inside them
        useful_words = 0;
        while (useful_words < RUN_WORDS)
        begin
            calm <= (useful_words >= 300 && useful_words < 450);
            if ($urandom_range(99) < 15)
                push_word(CMD_CLEAR, 9'($urandom), 1'b1);
            if ($urandom_range(99) < 10)
                push_word(CMD_LOAD, $urandom_range(1) ? 9'd0 : 9'($urandom_range(256, 511)),
                          1'b0);
            if ($urandom_range(99) < 5)
                push_word(CMD_CONT, 9'($urandom), 1'b0);

            // once: fill the program store and overflow it
            if (!filled && useful_words >= 600)
            begin
                filled = 1'b1;
                for (int i = 0; i < PROGRAM_DEPTH + 2; i++)
                begin
                    case ($urandom_range(0, 39))
                        0, 1:    push_word(CMD_LOAD, {1'b0, CH_INC}, 1'b0);
                        2:       push_word(CMD_LOAD, {1'b0, CH_OUT}, 1'b0);
                        default: push_word(CMD_LOAD, {1'b0, plain_char()}, 1'b0);
                    endcase
                end
                run_line();
            end

            compose_line();
            foreach (line_text[i])
                push_word(CMD_LOAD, {1'b0, line_text[i]}, 1'b1);
            if ($urandom_range(99) < 20)
                wait_drained();
            run_line();
        end

        // Drain and give the verdict
        calm <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- bf_tape_machine_interpreter.f -----
design/bfi_pkg.sv
design/bf_tape_machine_interpreter.sv
bench/bf_event_checker.sv
bench/tb_bf_tape_machine_interpreter.sv
